// ===== rtl/bwes_pkg.sv =====
// Shared types and constants for the braid word search core.
// Fixed-point formats, generator matrices and register indexes.
// No dependencies.
package bwes_pkg;

   // Q2.16 matrix entry
   localparam int FRAC_BITS = 16;
   localparam int ENTRY_W   = FRAC_BITS + 2;
   localparam int MAT_W     = 8 * ENTRY_W;
   localparam int ERR_W     = 2 * FRAC_BITS + 2;
   localparam int WORD_W    = 22;
   localparam int LEN_W     = 5;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic [ERR_W-1:0] err_type;

   localparam err_type ERR_MAX = '1;

   // configuration register indexes
   localparam logic [1:0] REG_MAX_DEPTH = 2'd0;
   localparam logic [1:0] REG_PRUNE     = 2'd1;

   // generators rounded to Q2.16; order m00 re/im, m01 re/im, m10 re/im, m11 re/im
   localparam entry_type GEN_TABLE [2][8] = '{
      '{-18'sd53020, -18'sd38521, 18'sd0, 18'sd0,
        18'sd0, 18'sd0, -18'sd20252, 18'sd62328},
      '{-18'sd32768, 18'sd23807, -18'sd15921, -18'sd49000,
        -18'sd15921, -18'sd49000, -18'sd40503, 18'sd0}
   };

endpackage

// ===== rtl/bwes_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// Holds the path matrices of the search core; no dependencies.
module bwes_ram #(
   parameter int WIDTH = 144,
   parameter int DEPTH = 23
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/braid_word_exhaustive_search_core.sv =====
// Depth-first exhaustive braid word search over two generators.
// Depends on bwes_pkg and bwes_ram (path matrix store).
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | 8 x Q2.16 target entries
//  rsp     | out | rsp_tvalid/rsp_tready | best word, length, squared error
//  csr     | in  | csr_we                | depth limit, prune threshold
//
// Each search node that gets children runs the difference products, the wide
// squares and the one-bit-per-cycle square root, the score, and the child
// matrix product on the shared 37x19 multiplier. A backtrack climbs the levels
// one by one and then reloads a parent from the path RAM. A node whose error
// sum is out of range skips the wide squares and the square root. A full search
// visits up to 2^(depth+1)-1 nodes. Reset is synchronous; a finished result
// waits in the output register while the next request is taken.
module braid_word_exhaustive_search_core #(
   parameter int MAX_LEVELS = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // t00_re, t00_im, t01_re, t01_im, t10_re, t10_im, t11_re, t11_im
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // word_bits[21:0], word_length[26:22], best_error[60:27], zero fill
   output logic [63:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [33:0]  csr_wdata
);

   localparam int LVL_W = $clog2(MAX_LEVELS + 1);
   localparam int EW    = bwes_pkg::ENTRY_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_DPROD = 4'd2;
   localparam logic [3:0] S_WIDE  = 4'd3;
   localparam logic [3:0] S_DISC  = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_SCORE = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_CHILD = 4'd8;
   localparam logic [3:0] S_POP   = 4'd9;
   localparam logic [3:0] S_READ  = 4'd10;
   localparam logic [3:0] S_LOAD  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [LVL_W-1:0] level_ff, level_in, lim_ff, lim_in;
   logic [MAX_LEVELS-1:0] letters_ff, letters_in, best_letters_ff, best_letters_in;
   logic [LVL_W-1:0] best_level_ff, best_level_in;
   logic        gen_sel_ff, gen_sel_in;
   bwes_pkg::entry_type cur_ff [8], cur_in [8];
   bwes_pkg::entry_type child_ff [8], child_in [8];
   bwes_pkg::entry_type tgt_ff [8], tgt_in [8];
   logic signed [39:0] acc_ff, acc_in;
   logic [39:0] a_ff, a_in;
   logic signed [40:0] dr_ff, dr_in, di_ff, di_in;
   logic [73:0] aa_ff, aa_in, bb_ff, bb_in;
   logic [69:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [34:0] root_ff, root_in;
   logic [34:0] best_ff, best_in;
   logic signed [55:0] prod_ff, prod_in;
   logic [4:0]  depth_cfg_ff;
   logic [33:0] prune_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic signed [36:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [18:0] d [8];
   logic        ram_we;
   logic [LVL_W-1:0] ram_addr;
   logic [bwes_pkg::MAT_W-1:0] ram_wdata, ram_rdata;

   // path matrix store, one row per level
   bwes_ram #(
      .WIDTH(bwes_pkg::MAT_W),
      .DEPTH(MAX_LEVELS + 1)
   ) u_path_ram (
      .clock(clock),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // differences to the target
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         d[i] = {cur_ff[i][EW-1], cur_ff[i]} - {tgt_ff[i][EW-1], tgt_ff[i]};
      end
   end

   // multiplier operand selection
   always_comb begin
      logic [2:0] dx, dy, gi, ci;
      logic [35:0] mdr, mdi, wx;
      logic [17:0] wy;
      dx = 3'd0;
      dy = 3'd0;
      gi = 3'd0;
      ci = 3'd0;
      mdr = dr_ff[40] ? 36'(-dr_ff) : 36'(dr_ff);
      mdi = di_ff[40] ? 36'(-di_ff) : 36'(di_ff);
      wx = a_ff[35:0];
      wy = 18'd0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DPROD: begin
            if (!cnt_ff[3]) begin
               dx = cnt_ff[2:0];
               dy = cnt_ff[2:0];
            end else begin
               unique case (cnt_ff[2:0])
                  3'd0: begin dx = 3'd0; dy = 3'd6; end
                  3'd1: begin dx = 3'd1; dy = 3'd7; end
                  3'd2: begin dx = 3'd2; dy = 3'd4; end
                  3'd3: begin dx = 3'd3; dy = 3'd5; end
                  3'd4: begin dx = 3'd0; dy = 3'd7; end
                  3'd5: begin dx = 3'd1; dy = 3'd6; end
                  3'd6: begin dx = 3'd2; dy = 3'd5; end
                  default: begin dx = 3'd3; dy = 3'd4; end
               endcase
            end
            mul_a = {{18{d[dx][18]}}, d[dx]};
            mul_b = d[dy];
         end
         S_WIDE: begin
            priority if (cnt_ff[2:1] == 2'd0) begin
               wx = a_ff[35:0];
            end else if (cnt_ff[2:1] == 2'd1) begin
               wx = mdr;
            end else begin
               wx = mdi;
            end
            wy = cnt_ff[0] ? wx[35:18] : wx[17:0];
            mul_a = {1'b0, wx};
            mul_b = {1'b0, wy};
         end
         S_MUL: begin
            // op = 4*entry + term; entry = {row, col, imag}
            gi = {cnt_ff[1], cnt_ff[3], cnt_ff[2] ^ cnt_ff[0]};
            ci = {cnt_ff[4], cnt_ff[1:0]};
            mul_a = {{19{cur_ff[ci][EW-1]}}, cur_ff[ci]};
            mul_b = {bwes_pkg::GEN_TABLE[gen_sel_ff][gi][EW-1],
                     bwes_pkg::GEN_TABLE[gen_sel_ff][gi]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // search sequencer
   always_comb begin
      logic [5:0]  op;
      logic signed [39:0] pv, sum, rnd;
      logic [75:0] four_b;
      logic [37:0] rem_sh, trial;
      logic [35:0] half;
      logic [33:0] err;
      logic [MAX_LEVELS-1:0] mask;
      logic [73:0] wp;
      logic [bwes_pkg::WORD_W+MAX_LEVELS-1:0] word_ext;
      state_in = state_ff;
      cnt_in = cnt_ff;
      level_in = level_ff;
      lim_in = lim_ff;
      letters_in = letters_ff;
      best_letters_in = best_letters_ff;
      best_level_in = best_level_ff;
      gen_sel_in = gen_sel_ff;
      cur_in = cur_ff;
      child_in = child_ff;
      tgt_in = tgt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      dr_in = dr_ff;
      di_in = di_ff;
      aa_in = aa_ff;
      bb_in = bb_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      best_in = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ram_we = 1'b0;
      ram_addr = level_ff;
      ram_wdata = '0;
      op = 6'(cnt_ff - 6'd1);
      pv = 40'(prod_ff);
      sum = '0;
      rnd = '0;
      four_b = {bb_ff, 2'b00};
      rem_sh = {rem_ff, rad_ff[69:68]};
      trial = {1'b0, root_ff, 2'b01};
      half = 36'({1'b0, a_ff[34:0]} + {1'b0, root_ff}) >> 1;
      err = (a_ff[39:35] != 5'd0 || half[35:34] != 2'd0) ? bwes_pkg::ERR_MAX : half[33:0];
      mask = MAX_LEVELS'(1) << (level_ff - LVL_W'(1));
      wp = 74'(prod_ff[53:0]);
      word_ext = {{bwes_pkg::WORD_W{1'b0}}, best_letters_ff};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 8; i++) begin
                  tgt_in[i] = req_tdata[i*EW +: EW];
               end
               lim_in = (32'(depth_cfg_ff) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                         : LVL_W'(depth_cfg_ff);
               level_in = '0;
               letters_in = '0;
               best_letters_in = '0;
               best_level_in = '0;
               best_in = '1;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // identity at level zero
            for (int i = 0; i < 8; i++) begin
               cur_in[i] = (i == 0 || i == 6) ? bwes_pkg::entry_type'(1 << bwes_pkg::FRAC_BITS)
                                              : bwes_pkg::entry_type'(0);
               ram_wdata[i*EW +: EW] = cur_in[i];
            end
            ram_we = 1'b1;
            ram_addr = '0;
            cnt_in = '0;
            state_in = S_DPROD;
         end
         S_DPROD: begin
            // squares into a, determinant terms into dr and di
            if (cnt_ff == 6'd0) begin
               a_in = '0;
               dr_in = '0;
               di_in = '0;
            end else if (!op[3]) begin
               a_in = a_ff + pv;
            end else if (!op[2]) begin
               dr_in = (op[1:0] == 2'd1 || op[1:0] == 2'd2) ? dr_ff - 41'(pv) : dr_ff + 41'(pv);
            end else begin
               di_in = op[1] ? di_ff - 41'(pv) : di_ff + 41'(pv);
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd16) begin
               cnt_in = '0;
               state_in = (a_in[39:35] != 5'd0) ? S_SCORE : S_WIDE;
            end
         end
         S_WIDE: begin
            // a*a and dr^2 + di^2 in half-width passes
            if (cnt_ff == 6'd0) begin
               aa_in = '0;
               bb_in = '0;
            end else if (op[2:1] == 2'd0) begin
               aa_in = aa_ff + (op[0] ? wp << 18 : wp);
            end else begin
               bb_in = bb_ff + (op[0] ? wp << 18 : wp);
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd6) begin
               cnt_in = '0;
               state_in = S_DISC;
            end
         end
         S_DISC: begin
            rad_in = ({2'b00, aa_ff} > four_b) ? 70'({2'b00, aa_ff} - four_b) : 70'd0;
            rem_in = '0;
            root_in = '0;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // one root bit per cycle
            if (rem_sh >= trial) begin
               rem_in = 36'(rem_sh - trial);
               root_in = {root_ff[33:0], 1'b1};
            end else begin
               rem_in = 36'(rem_sh);
               root_in = {root_ff[33:0], 1'b0};
            end
            rad_in = {rad_ff[67:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd34) begin
               cnt_in = '0;
               state_in = S_SCORE;
            end
         end
         S_SCORE: begin
            if ({1'b0, err} < best_ff) begin
               best_in = {1'b0, err};
               best_letters_in = letters_ff;
               best_level_in = level_ff;
            end
            if (level_ff < lim_ff && err >= prune_ff) begin
               gen_sel_in = 1'b0;
               cnt_in = '0;
               state_in = S_MUL;
            end else begin
               state_in = S_POP;
            end
         end
         S_MUL: begin
            // four products per child entry, then round and saturate
            if (cnt_ff != 6'd0) begin
               sum = ((op[1:0] == 2'd0) ? 40'sd0 : acc_ff)
                     + ((!op[2] && op[0]) ? -pv : pv);
               acc_in = sum;
               if (op[1:0] == 2'd3) begin
                  rnd = (sum + 40'sd32768) >>> bwes_pkg::FRAC_BITS;
                  priority if (rnd > 40'sd131071) begin
                     child_in[op[4:2]] = 18'sd131071;
                  end else if (rnd < -40'sd131072) begin
                     child_in[op[4:2]] = -18'sd131072;
                  end else begin
                     child_in[op[4:2]] = EW'(rnd);
                  end
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               cnt_in = '0;
               state_in = S_CHILD;
            end
         end
         S_CHILD: begin
            cur_in = child_ff;
            for (int i = 0; i < 8; i++) begin
               ram_wdata[i*EW +: EW] = child_ff[i];
            end
            ram_we = 1'b1;
            ram_addr = level_ff + LVL_W'(1);
            level_in = level_ff + LVL_W'(1);
            cnt_in = '0;
            state_in = S_DPROD;
         end
         S_POP: begin
            // climb until a parent still has its second child to try
            if (level_ff == '0) begin
               state_in = S_OUT;
            end else if ((letters_ff & mask) != '0) begin
               letters_in = letters_ff & ~mask;
               level_in = level_ff - LVL_W'(1);
            end else begin
               letters_in = letters_ff | mask;
               level_in = level_ff - LVL_W'(1);
               gen_sel_in = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            for (int i = 0; i < 8; i++) begin
               cur_in[i] = ram_rdata[i*EW +: EW];
            end
            cnt_in = '0;
            state_in = S_MUL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {3'b000, best_ff[33:0], bwes_pkg::LEN_W'(best_level_ff),
                  word_ext[bwes_pkg::WORD_W-1:0]};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_cfg_ff <= 5'd12;
         prune_ff <= 34'd1;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == bwes_pkg::REG_MAX_DEPTH) begin
            depth_cfg_ff <= csr_wdata[4:0];
         end
         if (csr_we && csr_addr == bwes_pkg::REG_PRUNE) begin
            prune_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      level_ff <= level_in;
      lim_ff <= lim_in;
      letters_ff <= letters_in;
      best_letters_ff <= best_letters_in;
      best_level_ff <= best_level_in;
      gen_sel_ff <= gen_sel_in;
      cur_ff <= cur_in;
      child_ff <= child_in;
      tgt_ff <= tgt_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      dr_ff <= dr_in;
      di_ff <= di_in;
      aa_ff <= aa_in;
      bb_ff <= bb_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      best_ff <= best_in;
      prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/bwes_checker.sv =====
// Port-level checks for the braid word search core.
// Bound to braid_word_exhaustive_search_core; no package use.
module bwes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a taken request keeps the core busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while searching");

   // word length no more than the 22-level cap
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:22] <= 5'd22)
      else $error("word length out of range");

endmodule

bind braid_word_exhaustive_search_core bwes_checker u_bwes_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for braid_word_exhaustive_search_core: a software braid
// search predicts each request's best word. Depends on bwes_pkg and the core.
module tb_top;

   typedef longint mat_type [8];
   typedef struct {
      logic [21:0] word;
      logic [4:0]  len;
      logic [33:0] err;
   } word_result_type;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [33:0]  csr_wdata = '0;

   logic [143:0] pending_targets [$];
   word_result_type expected_words [$];
   int           errors = 0;
   bit           calm = 1'b0;

   // register copies
   logic [4:0]  depth_setting = 5'd12;
   logic [33:0] prune_setting = 34'd1;

   // predictor state
   mat_type path_mats [0:22];
   mat_type gens [2];
   longint  tgt [8];

   braid_word_exhaustive_search_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint round_entry(longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r;
   endfunction

   function automatic void mat_mul(input mat_type x, input mat_type y, output mat_type z);
      longint re, im;
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 2; c++) begin
            re = x[4*r]*y[2*c] - x[4*r+1]*y[2*c+1] + x[4*r+2]*y[4+2*c] - x[4*r+3]*y[5+2*c];
            im = x[4*r]*y[2*c+1] + x[4*r+1]*y[2*c] + x[4*r+2]*y[5+2*c] + x[4*r+3]*y[4+2*c];
            z[4*r+2*c] = round_entry(re);
            z[4*r+2*c+1] = round_entry(im);
         end
      end
   endfunction

   // squared operator-norm distance to the target, Q2.32, saturating
   function automatic logic [33:0] braid_distance(input mat_type m);
      longint d [8];
      longint a, dr, di;
      logic [127:0] aa, fb, disc, mr, mi, root, cand;
      logic [63:0] s;
      a = 0;
      for (int i = 0; i < 8; i++) begin
         d[i] = m[i] - tgt[i];
         a += d[i] * d[i];
      end
      if (a >= (64'sd1 <<< 35)) return '1;
      dr = d[0]*d[6] - d[1]*d[7] - d[2]*d[4] + d[3]*d[5];
      di = d[0]*d[7] + d[1]*d[6] - d[2]*d[5] - d[3]*d[4];
      aa = {64'd0, a};
      aa = aa * aa;
      mr = {64'd0, (dr < 0) ? -dr : dr};
      mi = {64'd0, (di < 0) ? -di : di};
      fb = (mr * mr + mi * mi) << 2;
      disc = (aa > fb) ? aa - fb : '0;
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= disc) root = cand;
      end
      s = (a + root[63:0]) >> 1;
      return (s > 64'h3_FFFF_FFFF) ? '1 : s[33:0];
   endfunction

   // depth-first search over braid words, iterative
   function automatic word_result_type search_best_word(input logic [143:0] t);
      word_result_type best;
      logic [63:0] best_dist, err;
      logic [21:0] letters;
      bit branch [0:22];
      int lim, lvl;
      bit done, descended;
      for (int i = 0; i < 8; i++) tgt[i] = longint'($signed(t[18*i +: 18]));
      lim = (depth_setting > 22) ? 22 : int'(depth_setting);
      path_mats[0] = '{65536, 0, 0, 0, 0, 0, 65536, 0};
      letters = '0;
      best = '{word: '0, len: '0, err: '0};
      best_dist = '1;
      lvl = 0;
      done = 0;
      while (!done) begin
         err = {30'd0, braid_distance(path_mats[lvl])};
         if (err < best_dist) begin
            best_dist = err;
            best = '{word: letters, len: 5'(lvl), err: err[33:0]};
         end
         if (lvl < lim && err >= {30'd0, prune_setting}) begin
            branch[lvl] = 0;
            mat_mul(path_mats[lvl], gens[0], path_mats[lvl+1]);
            lvl++;
         end else begin
            descended = 0;
            while (!descended && !done) begin
               if (lvl == 0) begin
                  done = 1;
               end else begin
                  lvl--;
                  if (!branch[lvl]) begin
                     branch[lvl] = 1;
                     letters[lvl] = 1'b1;
                     mat_mul(path_mats[lvl], gens[1], path_mats[lvl+1]);
                     lvl++;
                     descended = 1;
                  end else begin
                     letters[lvl] = 1'b0;
                  end
               end
            end
         end
      end
      return best;
   endfunction

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_targets.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_targets.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 17);
   end

   // predict on accepted request, check accepted response
   always @(posedge clock) begin
      word_result_type got, want;
      if (!reset && req_tvalid && req_tready)
         expected_words.push_back(search_best_word(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{word: rsp_tdata[21:0], len: rsp_tdata[26:22], err: rsp_tdata[60:27]};
         if (expected_words.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = expected_words.pop_front();
            if (got.word !== want.word)
               report($sformatf("word_bits %h, want %h", got.word, want.word));
            if (got.len !== want.len)
               report($sformatf("word_length %0d, want %0d", got.len, want.len));
            if (got.err !== want.err)
               report($sformatf("best_error %h, want %h", got.err, want.err));
         end
      end
   end

   task automatic drain();
      while (pending_targets.size() > 0 || req_tvalid || expected_words.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [33:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == bwes_pkg::REG_MAX_DEPTH) depth_setting = value[4:0];
      else if (addr == bwes_pkg::REG_PRUNE) prune_setting = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [143:0] pack(input longint e [8]);
      logic [143:0] v;
      for (int i = 0; i < 8; i++) v[18*i +: 18] = 18'(e[i]);
      return v;
   endfunction

   function automatic logic [143:0] near_identity();
      longint e [8];
      e = '{65536, 0, 0, 0, 0, 0, 65536, 0};
      for (int i = 0; i < 8; i++) e[i] += longint'($urandom_range(1024)) - 512;
      return pack(e);
   endfunction

   function automatic logic [143:0] any_target();
      logic [143:0] v;
      for (int i = 0; i < 8; i++) v[18*i +: 18] = 18'($urandom);
      return v;
   endfunction

   // generators rounded from Q.31
   initial begin
      longint q31 [2][8];
      q31 = '{'{-1737350766, -1262259218, 0, 0, 0, 0, -663608942, 2042378318},
              '{-1073741824, 780119099, -521697084, -1605618528,
                -521697084, -1605618528, -1327217885, 0}};
      for (int g = 0; g < 2; g++)
         for (int i = 0; i < 8; i++)
            gens[g][i] = (q31[g][i] + (64'sd1 <<< 14)) >>> 15;
   end

   // stimulus
   initial begin
      longint e [8];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: shallow full search
      write_reg(bwes_pkg::REG_MAX_DEPTH, 34'd3);
      write_reg(bwes_pkg::REG_PRUNE, 34'd0);
      write_reg(REG_UNUSED, '1);
      pending_targets.push_back(pack('{65536, 0, 0, 0, 0, 0, 65536, 0}));
      pending_targets.push_back('0);
      pending_targets.push_back({8{18'h1FFFF}});
      pending_targets.push_back({8{18'h20000}});
      pending_targets.push_back({4{18'h1FFFF, 18'h20000}});
      pending_targets.push_back(pack('{-65536, 0, 0, 0, 0, 0, -65536, 0}));
      pending_targets.push_back(pack(gens[0]));
      pending_targets.push_back(pack(gens[1]));
      mat_mul(gens[0], gens[1], e);
      pending_targets.push_back(pack(e));
      mat_mul(e, gens[1], e);
      pending_targets.push_back(pack(e));
      for (int i = 0; i < 8; i++) begin
         pending_targets.push_back(144'(18'h1FFFF) << (18*i));
      end
      drain();

      // zero depth: only the empty word
      write_reg(bwes_pkg::REG_MAX_DEPTH, 34'd0);
      pending_targets.push_back(pack(gens[0]));
      pending_targets.push_back(any_target());
      drain();

      // depth over the cap with the largest threshold: the root prunes
      write_reg(bwes_pkg::REG_MAX_DEPTH, 34'd31);
      write_reg(bwes_pkg::REG_PRUNE, '1);
      for (int i = 0; i < 4; i++) pending_targets.push_back(near_identity());
      drain();

      // random phases, first one without idling
      for (int p = 0; p < 5; p++) begin
         calm = (p == 0);
         write_reg(bwes_pkg::REG_MAX_DEPTH, 34'($urandom_range(5)));
         case ($urandom_range(2))
            0: write_reg(bwes_pkg::REG_PRUNE, 34'd0);
            1: write_reg(bwes_pkg::REG_PRUNE, 34'($urandom_range(32'h4000_0000)));
            default: write_reg(bwes_pkg::REG_PRUNE, {2'($urandom), 32'($urandom)});
         endcase
         for (int i = 0; i < 16; i++)
            pending_targets.push_back(($urandom_range(2) == 0) ? near_identity() : any_target());
         drain();
      end

      repeat (300) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bwes_pkg.sv
rtl/bwes_ram.sv
rtl/braid_word_exhaustive_search_core.sv
rtl/bwes_checker.sv
tb/tb_top.sv
